### sv/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// shared types and constants of the fit policy block allocator
// ----------------------------------------------------------------------------
package fpba_pkg;

    localparam int NUM_BLOCKS = 32;
    localparam int SIZE_BITS  = 16;
    localparam int REQ_BITS   = 16;
    localparam int IDX_BITS   = 5;
    localparam int LIMIT_BITS = 6;
    localparam int MODE_BITS  = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 6;
    localparam int CMP_BITS   = (SIZE_BITS > REQ_BITS) ? SIZE_BITS : REQ_BITS;
    localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

    localparam logic [MODE_BITS-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_BITS-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_BITS-1:0] FIT_WORST = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_FIT_MODE          = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PARTITIONS_IN_USE = 1'd1;

    typedef logic [SIZE_BITS-1:0] size_t;
    typedef logic [REQ_BITS-1:0]  req_t;
    typedef logic [IDX_BITS-1:0]  idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // candidate handed from cell to cell
    typedef struct packed {
        logic  found;
        idx_t  pick;
        size_t value;
    } token_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                  load_en;
        idx_t                  load_index;
        size_t                 load_value;
        logic                  wb_en;
        idx_t                  wb_index;
        req_t                  request;
        logic [MODE_BITS-1:0]  mode;
        logic [LIMIT_BITS-1:0] limit;
    } cell_ctrl_t;

endpackage

### sv/fpba_cell.sv
// ----------------------------------------------------------------------------
// fpba_cell
// one partition: holds its remaining size and updates the passing candidate
// ----------------------------------------------------------------------------
module fpba_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  fpba_pkg::idx_t   my_index,
    input  fpba_pkg::cell_ctrl_t ctrl,
    input  fpba_pkg::token_t tok_in,
    output fpba_pkg::token_t tok_out
);
    import fpba_pkg::*;

    size_t  value_reg;
    size_t  value_next;
    token_t tok_reg;
    token_t tok_next;

    logic [CMP_BITS-1:0] value_ext;
    logic [CMP_BITS-1:0] req_ext;
    logic [CMP_BITS-1:0] diff;
    logic active;
    logic fits;
    logic better;

    assign value_ext = CMP_BITS'(value_reg);
    assign req_ext   = CMP_BITS'(ctrl.request);
    assign diff      = value_ext - req_ext;
    assign active    = {1'b0, my_index} < ctrl.limit;
    assign fits      = active && (value_ext >= req_ext);

    always_comb
    begin
        better = 1'b0;
        if (ctrl.mode == FIT_BEST)
        begin
            better = value_reg < tok_in.value;
        end
        else if (ctrl.mode == FIT_WORST)
        begin
            better = value_reg > tok_in.value;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (fits && (!tok_in.found || better))
        begin
            tok_next.found = 1'b1;
            tok_next.pick  = my_index;
            tok_next.value = value_reg;
        end
    end

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load_en && ctrl.load_index == my_index)
        begin
            value_next = ctrl.load_value;
        end
        else if (ctrl.wb_en && ctrl.wb_index == my_index)
        begin
            value_next = diff[SIZE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### sv/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// first, best and worst fit partition allocator built as a chain of cells
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  request   | start, busy            | operation, partition_index, size_value
//  result    | done (one-cycle strobe)| granted, chosen_partition
//  config    | cfg_we                 | cfg_index, cfg_data
//
//  a load is written straight into its cell and leaves busy low
//  an allocate is accepted, then the candidate walks the cell chain one cell
//  per cycle in ST_SCAN, then ST_WRITE writes back; done follows
//  rst_n clears control state; partition sizes are undefined until loaded
//  results cannot be stalled
// ----------------------------------------------------------------------------
module fit_policy_block_allocator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  operation,
    input  logic [fpba_pkg::IDX_BITS-1:0]         partition_index,
    input  logic [fpba_pkg::REQ_BITS-1:0]         size_value,
    output logic                                  done,
    output logic                                  granted,
    output logic [fpba_pkg::IDX_BITS-1:0]         chosen_partition,
    input  logic                                  cfg_we,
    input  logic [fpba_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [fpba_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import fpba_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;
    req_t                  request_reg;
    logic [MODE_BITS-1:0]  mode_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic                  done_reg;
    logic                  granted_reg;
    idx_t                  chosen_reg;

    logic       accept;
    logic       scan_last;
    cell_ctrl_t ctrl;
    token_t     chain [0:NUM_BLOCKS];

    assign accept    = start && !busy;
    assign scan_last = cnt_reg == CNT_BITS'(NUM_BLOCKS - 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept && operation == OP_ALLOC)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (scan_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy            = 1'b1;
        ctrl.load_en    = 1'b0;
        ctrl.wb_en      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy         = 1'b0;
                ctrl.load_en = start && operation == OP_LOAD;
            end
            ST_SCAN:
            begin
                busy = 1'b1;
            end
            ST_WRITE:
            begin
                ctrl.wb_en = chain[NUM_BLOCKS].found;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
        ctrl.load_index = partition_index;
        ctrl.load_value = SIZE_BITS'(size_value);
        ctrl.wb_index   = chain[NUM_BLOCKS].pick;
        ctrl.request    = request_reg;
        ctrl.mode       = mode_reg;
        ctrl.limit      = limit_reg;
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < NUM_BLOCKS; i++)
    begin : g_cell
        fpba_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_index (IDX_BITS'(i)),
            .ctrl     (ctrl),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mode_reg  <= FIT_FIRST;
            limit_reg <= LIMIT_BITS'(32);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= state_reg == ST_WRITE;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FIT_MODE:          mode_reg  <= cfg_data[MODE_BITS-1:0];
                    REG_PARTITIONS_IN_USE: limit_reg <= cfg_data[LIMIT_BITS-1:0];
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            request_reg <= size_value;
        end
        if (state_reg == ST_WRITE)
        begin
            granted_reg <= chain[NUM_BLOCKS].found;
            chosen_reg  <= chain[NUM_BLOCKS].found ? chain[NUM_BLOCKS].pick : '0;
        end
    end

    assign done             = done_reg;
    assign granted          = granted_reg;
    assign chosen_partition = chosen_reg;

    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_WRITE))
        else $error("result without write-back");

    a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !ctrl.load_en)
        else $error("load while busy");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> cnt_reg < CNT_BITS'(NUM_BLOCKS))
        else $error("scan counter overran");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && granted) |-> ({1'b0, chosen_partition} < limit_reg))
        else $error("granted partition outside searched range");

endmodule

### sim/tb_fit_policy_block_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fit_policy_block_allocator
// self-checking bench for the first, best and worst fit partition allocator
//
// A directed table covers reset, the size extremes, every fit mode, mode
// masking, ties, an empty search, and search limits of zero, one, and above
// the partition count. Random phases follow, each under its own mode, limit
// and request pacing. Every grant is checked field by field against an
// in-bench copy of the partition table.
// ----------------------------------------------------------------------------
module tb_fit_policy_block_allocator;

    import fpba_pkg::*;

    typedef struct packed {
        logic granted;
        idx_t part;
    } grant_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_BITS-1:0]  reg_sel;
        logic [CFG_DATA_BITS-1:0] cfg_value;
        logic                     op;
        idx_t                     idx;
        req_t                     size;
        logic                     fixed_exp;
        logic                     granted;
        idx_t                     part;
    } step_t;

    localparam int NUM_STEPS  = 26;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_REQS = 50;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 5000;

    // rows with fixed_exp set carry their expected grant, the rest use the model
    localparam step_t DIRECTED_STEPS [NUM_STEPS] = '{
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'd0, 1'b1, 1'b1, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'd1, 1'b1, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_LOAD, 5'd31, 16'hFFFF, 1'b0, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_LOAD, 5'd0, 16'd100, 1'b0, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_LOAD, 5'd5, 16'd40, 1'b0, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_LOAD, 5'd9, 16'd100, 1'b0, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'hFFFF, 1'b1, 1'b1, 5'd31},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'hFFFF, 1'b1, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'd30, 1'b0, 1'b0, 5'd0},
        // upper data bits must be dropped, leaving best fit
        '{ROW_CFG, REG_FIT_MODE, 6'h3D, OP_LOAD, 5'd0, 16'd0, 1'b0, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'd30, 1'b0, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'd70, 1'b0, 1'b0, 5'd0},
        '{ROW_CFG, REG_FIT_MODE, 6'(FIT_WORST), OP_LOAD, 5'd0, 16'd0, 1'b0, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'd10, 1'b0, 1'b0, 5'd0},
        // tie between partitions 3 and 9
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_LOAD, 5'd3, 16'd90, 1'b0, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'd5, 1'b0, 1'b0, 5'd0},
        // unused mode code
        '{ROW_CFG, REG_FIT_MODE, 6'd3, OP_LOAD, 5'd0, 16'd0, 1'b0, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'd5, 1'b0, 1'b0, 5'd0},
        '{ROW_CFG, REG_PARTITIONS_IN_USE, 6'd0, OP_LOAD, 5'd0, 16'd0, 1'b0, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'd0, 1'b1, 1'b0, 5'd0},
        '{ROW_CFG, REG_PARTITIONS_IN_USE, 6'd63, OP_LOAD, 5'd0, 16'd0, 1'b0, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'd90, 1'b0, 1'b0, 5'd0},
        '{ROW_CFG, REG_PARTITIONS_IN_USE, 6'd1, OP_LOAD, 5'd0, 16'd0, 1'b0, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'd1, 1'b1, 1'b0, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd0, 16'd0, 1'b1, 1'b1, 5'd0},
        '{ROW_REQ, REG_FIT_MODE, 6'd0, OP_ALLOC, 5'd7, 16'd0, 1'b1, 1'b1, 5'd0}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     operation = OP_LOAD;
    idx_t                     partition_index = '0;
    req_t                     size_value = '0;
    logic                     done;
    logic                     granted;
    idx_t                     chosen_partition;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    size_t                 part_size [NUM_BLOCKS];
    logic [MODE_BITS-1:0]  mode_sel = FIT_FIRST;
    logic [LIMIT_BITS-1:0] search_limit = LIMIT_BITS'(NUM_BLOCKS);
    grant_t                pending_grants [$];
    int                    mismatch_count = 0;
    int                    idle_pct = 0;

    fit_policy_block_allocator u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .partition_index  (partition_index),
        .size_value       (size_value),
        .done             (done),
        .granted          (granted),
        .chosen_partition (chosen_partition),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int searched_parts();
        return (int'(search_limit) > NUM_BLOCKS) ? NUM_BLOCKS : int'(search_limit);
    endfunction

    // fit search over the partition table, takes the request from the chosen entry
    function automatic grant_t fit_allocate(req_t req);
        grant_t res;
        logic   found;
        idx_t   pick;
        found = 1'b0;
        pick  = '0;
        for (int j = 0; j < searched_parts(); j++)
        begin
            if (part_size[j] >= req)
            begin
                if (!found)
                begin
                    found = 1'b1;
                    pick  = idx_t'(j);
                    if (mode_sel != FIT_BEST && mode_sel != FIT_WORST)
                        break;
                end
                else if (mode_sel == FIT_BEST && part_size[j] < part_size[pick])
                    pick = idx_t'(j);
                else if (mode_sel == FIT_WORST && part_size[j] > part_size[pick])
                    pick = idx_t'(j);
            end
        end
        res = '0;
        if (found)
        begin
            part_size[pick] = part_size[pick] - req;
            res.granted = 1'b1;
            res.part    = pick;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        grant_t exp_grant;
        if (rst_n && done)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t: grant with no request pending: granted %0b partition %0d",
                         $time, granted, chosen_partition);
                mismatch_count++;
            end
            else
            begin
                exp_grant = pending_grants.pop_front();
                if (granted !== exp_grant.granted)
                begin
                    $display("%0t: granted expected %0b got %0b",
                             $time, exp_grant.granted, granted);
                    mismatch_count++;
                end
                if (chosen_partition !== exp_grant.part)
                begin
                    $display("%0t: chosen_partition expected %0d got %0d",
                             $time, exp_grant.part, chosen_partition);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_request(input logic op, input idx_t idx, input req_t sz,
                                input logic fixed_exp, input grant_t fixed_grant);
        int     gap;
        grant_t res;
        gap = 0;
        if (idle_pct != 0)
        begin
            if ($urandom_range(99) < 4)
                gap = $urandom_range(1, 40);
            else
                while ($urandom_range(99) < idle_pct)
                    gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        operation       <= op;
        partition_index <= idx;
        size_value      <= sz;
        do
            @(posedge clk);
        while (busy);
        if (op == OP_ALLOC)
        begin
            res = fit_allocate(sz);
            pending_grants.push_back(fixed_exp ? fixed_grant : res);
        end
        else
            part_size[idx] = sz;
    endtask

    // hold requests off until every grant is back, then let the block go idle
    task automatic settle();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_grants.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_grants.size() != 0)
        begin
            $display("%0t: %0d grants never arrived", $time, pending_grants.size());
            mismatch_count += pending_grants.size();
            pending_grants.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] sel,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        if (sel == REG_FIT_MODE)
            mode_sel = value[MODE_BITS-1:0];
        else if (sel == REG_PARTITIONS_IN_USE)
            search_limit = value[LIMIT_BITS-1:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_request();
        int   pick;
        int   lim;
        int   margin;
        idx_t idx;
        req_t sz;
        pick = $urandom_range(99);
        idx  = idx_t'($urandom_range(NUM_BLOCKS - 1));
        lim  = searched_parts();
        if (pick < 30)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                sz = req_t'($urandom());
            else if (pick < 60)
                sz = part_size[$urandom_range(NUM_BLOCKS - 1)];
            else if (pick < 90)
                sz = req_t'($urandom_range(1023));
            else
                sz = $urandom_range(1) ? '1 : '0;
            send_request(OP_LOAD, idx, sz, 1'b0, '0);
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 50 && lim > 0)
            begin
                sz     = part_size[$urandom_range(lim - 1)];
                margin = (sz < 3) ? int'(sz) : 3;
                sz     = sz - req_t'($urandom_range(margin));
            end
            else if (pick < 70)
                sz = req_t'($urandom_range(255));
            else if (pick < 90)
                sz = req_t'($urandom());
            else
                sz = $urandom_range(1) ? '1 : '0;
            send_request(OP_ALLOC, idx, sz, 1'b0, '0);
        end
    endtask

    initial
    begin
        grant_t                   row_grant;
        logic [CFG_DATA_BITS-1:0] limit_value;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every partition gets a size before any search can read it
        for (int i = 0; i < NUM_BLOCKS; i++)
            send_request(OP_LOAD, idx_t'(i), '0, 1'b0, '0);

        for (int s = 0; s < NUM_STEPS; s++)
        begin
            if (DIRECTED_STEPS[s].kind == ROW_CFG)
            begin
                settle();
                write_register(DIRECTED_STEPS[s].reg_sel, DIRECTED_STEPS[s].cfg_value);
            end
            else
            begin
                row_grant.granted = DIRECTED_STEPS[s].granted;
                row_grant.part    = DIRECTED_STEPS[s].part;
                send_request(DIRECTED_STEPS[s].op, DIRECTED_STEPS[s].idx,
                             DIRECTED_STEPS[s].size, DIRECTED_STEPS[s].fixed_exp, row_grant);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case (p)
                0: limit_value = CFG_DATA_BITS'(NUM_BLOCKS);
                1: limit_value = 6'd1;
                2: limit_value = 6'd0;
                3: limit_value = 6'd63;
                default:
                    limit_value = ($urandom_range(99) < 70) ?
                                  CFG_DATA_BITS'($urandom_range(1, NUM_BLOCKS)) :
                                  CFG_DATA_BITS'($urandom_range(63));
            endcase
            write_register(REG_FIT_MODE,
                           {4'($urandom_range(15)), MODE_BITS'(p % 4)});
            write_register(REG_PARTITIONS_IN_USE, limit_value);
            idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 45 : 15);
            for (int k = 0; k < PHASE_REQS; k++)
            begin
                if ($urandom_range(99) < 2)
                    settle();
                send_random_request();
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("tb_fit_policy_block_allocator: done, clean");
        else
            $display("tb_fit_policy_block_allocator: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_fit_policy_block_allocator: done, errors");
        $finish;
    end

endmodule

### sim.f
sv/fpba_pkg.sv
sv/fpba_cell.sv
sv/fit_policy_block_allocator.sv
sim/tb_fit_policy_block_allocator.sv
